// ===== hw/rtl/wbpr_pkg.sv =====
// Package for the word-break prefix reach block: command codes.
package wbpr_pkg;

  typedef enum logic [1:0] {
    CMD_DICT  = 2'd0,
    CMD_TEXT  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

endpackage

// ===== hw/rtl/wbpr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wbpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/wbpr_match.sv =====
// Matcher: checks whether one stored word ends at the newest text byte.
module wbpr_match #(
  parameter int MAX_WORD_LEN = 16,
  localparam int SLW = $clog2(MAX_WORD_LEN + 1)
) (
  input  logic [8*MAX_WORD_LEN-1:0] recent_i, // byte 0 = newest
  input  logic [8*MAX_WORD_LEN-1:0] row_i,    // byte 0 = first letter
  input  logic [SLW-1:0]            len_i,
  input  logic [MAX_WORD_LEN-1:0]   reach_i,
  output logic                      hit_o
);

  logic reach_ok;
  logic all_eq;

  // recent byte j lines up with word byte len-1-j
  always_comb begin
    reach_ok = 1'b0;
    all_eq   = 1'b1;
    for (int k = 0; k < MAX_WORD_LEN; k++) begin
      if (int'(len_i) == k + 1) begin
        reach_ok = reach_i[k];
      end
    end
    for (int j = 0; j < MAX_WORD_LEN; j++) begin
      for (int p = 0; p < MAX_WORD_LEN; p++) begin
        if (int'(len_i) == p + j + 1) begin
          if (recent_i[8*j +: 8] != row_i[8*p +: 8]) begin
            all_eq = 1'b0;
          end
        end
      end
    end
    hit_o = (len_i != '0) && reach_ok && all_eq;
  end

endmodule

// ===== hw/rtl/word_break_prefix_reach_core.sv =====
// Top level of the word-break prefix reach block.
//
// Usage: items arrive on the in_ channel (valid/ready). in_command selects a
// dictionary byte, a text byte or a clear of the dictionary and overflow flag.
// Dictionary bytes are gathered in a word buffer and the whole word, with its
// length, is written as one row of the dictionary RAM on its final byte
// unless it is too long or the table is full, which sets the overflow flag
// instead; they give no result. Each text byte shifts the recent-byte line and
// then scans the stored words one RAM row per cycle; a word counts when its
// bytes match the newest text bytes and the prefix before it was reachable.
// One result transfer on the out_ channel follows each text byte. Each row
// read is registered in the RAM and checked by the matcher while the next
// row is read; the store state then posts the result, and an empty dictionary
// skips the scan. A new item is taken only once the previous one is done.
// The output register holds a result while out_ready is low; the block keeps
// taking dictionary and clear items, but a text byte waits in the store state
// to post its result until the register is free, and no item is taken
// meanwhile. Reset empties the dictionary and flag, clears the recent bytes
// and leaves only the empty prefix reachable; the RAM needs no clearing pass.
// Reads and writes of the RAM never overlap: writes happen only when idle.
module word_break_prefix_reach_core #(
  parameter int MAX_WORD_LEN = 16,
  parameter int DICT_WORDS   = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_command,
  input  logic [7:0] in_char_code,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_prefix_breakable,
  output logic       out_text_end,
  output logic       out_dict_overflow
);

  localparam int SLW   = $clog2(MAX_WORD_LEN + 1);  // stored length
  localparam int LLW   = $clog2(MAX_WORD_LEN + 2);  // loading length, saturates
  localparam int CW    = $clog2(DICT_WORDS + 1);    // word count
  localparam int AW    = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1;
  localparam int ROW_W = 8 * MAX_WORD_LEN + SLW;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_STORE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0]           word_count_r, word_count_nxt;
  logic [LLW-1:0]          load_len_r, load_len_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [7:0]              recent_r [MAX_WORD_LEN];
  logic [7:0]              recent_nxt [MAX_WORD_LEN];
  logic [7:0]              stage_r [MAX_WORD_LEN];
  logic [7:0]              stage_nxt [MAX_WORD_LEN];
  logic [MAX_WORD_LEN-1:0] reach_r, reach_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic                    pend_r;
  logic                    hit_r, hit_nxt;
  logic                    last_r, last_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_brk_r, out_brk_nxt;
  logic                    out_end_r, out_end_nxt;
  logic                    out_ovf_r, out_ovf_nxt;

  logic                    in_fire;
  logic                    slot_free;
  logic                    issue;
  logic [LLW-1:0]          load_len_inc;
  wbpr_pkg::cmd_t          cmd;

  logic                    ram_we;
  logic                    ram_re;
  logic [ROW_W-1:0]        ram_wdata;
  logic [ROW_W-1:0]        ram_rdata;
  logic [8*MAX_WORD_LEN-1:0] stage_flat;
  logic [8*MAX_WORD_LEN-1:0] recent_flat;
  logic                    match_hit;

  assign cmd       = wbpr_pkg::cmd_t'(in_command);
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign issue     = (state_r == ST_SCAN) && (idx_r < word_count_r);
  assign ram_re    = issue;

  assign load_len_inc = (load_len_r <= LLW'(MAX_WORD_LEN)) ? load_len_r + LLW'(1)
                                                          : load_len_r;

  always_comb begin
    for (int i = 0; i < MAX_WORD_LEN; i++) begin
      stage_flat[8*i +: 8]  = stage_nxt[i];
      recent_flat[8*i +: 8] = recent_r[i];
    end
  end

  assign ram_wdata = {load_len_inc[SLW-1:0], stage_flat};

  wbpr_ram #(
    .WIDTH (ROW_W),
    .DEPTH (DICT_WORDS)
  ) u_dict_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (word_count_r[AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  wbpr_match #(
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_match (
    .recent_i (recent_flat),
    .row_i    (ram_rdata[8*MAX_WORD_LEN-1:0]),
    .len_i    (ram_rdata[ROW_W-1 -: SLW]),
    .reach_i  (reach_r),
    .hit_o    (match_hit)
  );

  always_comb begin
    state_nxt      = state_r;
    word_count_nxt = word_count_r;
    load_len_nxt   = load_len_r;
    ovf_nxt        = ovf_r;
    recent_nxt     = recent_r;
    stage_nxt      = stage_r;
    reach_nxt      = reach_r;
    idx_nxt        = idx_r;
    hit_nxt        = hit_r;
    last_nxt       = last_r;
    ram_we         = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_brk_nxt    = out_brk_r;
    out_end_nxt    = out_end_r;
    out_ovf_nxt    = out_ovf_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (cmd)
            wbpr_pkg::CMD_DICT: begin
              for (int p = 0; p < MAX_WORD_LEN; p++) begin
                if (int'(load_len_r) == p) begin
                  stage_nxt[p] = in_char_code;
                end
              end
              load_len_nxt = load_len_inc;
              if (in_last_char) begin
                if (load_len_inc > LLW'(MAX_WORD_LEN) ||
                    word_count_r >= CW'(DICT_WORDS)) begin
                  ovf_nxt = 1'b1;
                end else begin
                  ram_we         = 1'b1;
                  word_count_nxt = word_count_r + CW'(1);
                end
                load_len_nxt = '0;
              end
            end
            wbpr_pkg::CMD_TEXT: begin
              recent_nxt[0] = in_char_code;
              for (int i = 1; i < MAX_WORD_LEN; i++) begin
                recent_nxt[i] = recent_r[i-1];
              end
              last_nxt = in_last_char;
              hit_nxt  = 1'b0;
              idx_nxt  = '0;
              // empty dictionary: nothing to scan
              state_nxt = (word_count_r == '0) ? ST_STORE : ST_SCAN;
            end
            wbpr_pkg::CMD_CLEAR: begin
              word_count_nxt = '0;
              load_len_nxt   = '0;
              ovf_nxt        = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // row issued last cycle is evaluated now
        if (pend_r && match_hit) begin
          hit_nxt = 1'b1;
        end
        if (issue) begin
          idx_nxt = idx_r + CW'(1);
        end else begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_brk_nxt   = hit_r;
          out_end_nxt   = last_r;
          out_ovf_nxt   = ovf_r;
          reach_nxt     = last_r ? MAX_WORD_LEN'(1)
                                 : (reach_r << 1) | MAX_WORD_LEN'(hit_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      word_count_r <= '0;
      load_len_r   <= '0;
      ovf_r        <= 1'b0;
      reach_r      <= MAX_WORD_LEN'(1);
      idx_r        <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < MAX_WORD_LEN; i++) begin
        recent_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      word_count_r <= word_count_nxt;
      load_len_r   <= load_len_nxt;
      ovf_r        <= ovf_nxt;
      reach_r      <= reach_nxt;
      idx_r        <= idx_nxt;
      pend_r       <= ram_re;
      out_valid_r  <= out_valid_nxt;
      recent_r     <= recent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stage_r   <= stage_nxt;
    hit_r     <= hit_nxt;
    last_r    <= last_nxt;
    out_brk_r <= out_brk_nxt;
    out_end_r <= out_end_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_prefix_breakable = out_brk_r;
  assign out_text_end         = out_end_r;
  assign out_dict_overflow    = out_ovf_r;

  // RAM is written only between text bytes, never during a scan
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == ST_IDLE)
    else $error("dictionary write during scan");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> idx_r <= word_count_r)
    else $error("scan index beyond word count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    word_count_r <= CW'(DICT_WORDS))
    else $error("word count beyond dictionary size");

  // the last row of a scan is always evaluated before the result is posted
  a_scan_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && !issue) |-> pend_r)
    else $error("scan ended without evaluating last row");

  a_empty_dict: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && cmd == wbpr_pkg::CMD_TEXT && word_count_r == '0) |=>
      state_r == ST_STORE)
    else $error("empty dictionary did not skip scan");

endmodule

// ===== tb/word_break_prefix_reach_core_test.sv =====
// Self-checking testbench for the word-break prefix reach block.
module word_break_prefix_reach_core_test;

  localparam int WORD_LEN    = 16;    // longest word kept
  localparam int N_WORDS     = 32;    // dictionary rows
  localparam int ITEM_TARGET = 750;   // items sent before the stimulus stops
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int TAIL_CYCLES = 40;    // full-dictionary latency plus margin

  // One result transfer as it should appear on the out_ channel.
  typedef struct packed {
    logic breakable;
    logic text_end;
    logic overflow;
  } reach_result_t;

  // One row of the directed table; reps repeats the same transfer.
  typedef struct {
    wbpr_pkg::cmd_t cmd;
    logic [7:0]     ch;
    logic           last;
    int             reps;
    bit             typed;
    reach_result_t  res;
  } stim_row_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  wbpr_pkg::cmd_t in_command = wbpr_pkg::CMD_NONE;
  logic [7:0]     in_char_code = 8'h00;
  logic           in_last_char = 1'b0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  logic           out_prefix_breakable;
  logic           out_text_end;
  logic           out_dict_overflow;

  word_break_prefix_reach_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_char_code        (in_char_code),
    .in_last_char        (in_last_char),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_prefix_breakable(out_prefix_breakable),
    .out_text_end        (out_text_end),
    .out_dict_overflow   (out_dict_overflow)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mirror of the block's state, kept by the predictor below.
  logic [7:0]          dict_bytes [N_WORDS][WORD_LEN];
  int                  dict_len [N_WORDS];
  int                  word_count;
  int                  loading_len;     // saturates at WORD_LEN + 1
  logic [7:0]          recent_bytes [WORD_LEN];   // newest first
  logic [WORD_LEN-1:0] reach;           // bit k: prefix k bytes back splits
  logic                overflow;

  reach_result_t pending_results [$];   // oldest first
  int            fail_count = 0;
  int            items_sent = 0;        // ignored commands not counted
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  bit            hold_request = 1'b0;
  logic [7:0]    alphabet [3];

  function automatic void reach_reset();
    word_count  = 0;
    loading_len = 0;
    overflow    = 1'b0;
    reach       = WORD_LEN'(1);
    foreach (recent_bytes[i]) recent_bytes[i] = 8'h00;
  endfunction

  // Applies one input transfer to the mirror; returns 1 when a result is due.
  function automatic bit reach_step(wbpr_pkg::cmd_t cmd, logic [7:0] ch, logic last,
                                    output reach_result_t res);
    bit hit;
    bit same;
    int len;
    res = '0;
    hit = 1'b0;
    case (cmd)
      wbpr_pkg::CMD_DICT: begin
        if (loading_len < WORD_LEN && word_count < N_WORDS)
          dict_bytes[word_count][loading_len] = ch;
        if (loading_len <= WORD_LEN) loading_len++;
        if (last) begin
          // over-long word or full table: drop it, raise the sticky flag
          if (loading_len > WORD_LEN || word_count >= N_WORDS) begin
            overflow = 1'b1;
          end else begin
            dict_len[word_count] = loading_len;
            word_count++;
          end
          loading_len = 0;
        end
        return 1'b0;
      end
      wbpr_pkg::CMD_CLEAR: begin
        // text in progress survives a clear
        word_count  = 0;
        loading_len = 0;
        overflow    = 1'b0;
        return 1'b0;
      end
      wbpr_pkg::CMD_TEXT: begin
        for (int i = WORD_LEN - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
        recent_bytes[0] = ch;
        for (int w = 0; w < word_count && !hit; w++) begin
          len = dict_len[w];
          if (reach[len-1]) begin
            same = 1'b1;
            for (int j = 0; j < len; j++)
              if (recent_bytes[j] != dict_bytes[w][len-1-j]) same = 1'b0;
            hit = same;
          end
        end
        if (last) reach = WORD_LEN'(1);
        else reach = {reach[WORD_LEN-2:0], hit};
        res.breakable = hit;
        res.text_end  = last;
        res.overflow  = overflow;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Offers one transfer on the in_ channel, with random gaps beforehand.
  // The expectation is queued at the edge the transfer is taken.
  task automatic send_item(wbpr_pkg::cmd_t cmd, logic [7:0] ch, logic last,
                           bit typed = 1'b0, reach_result_t typed_res = '0);
    reach_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_char_code <= ch;
    in_last_char <= last;
    do @(posedge clk); while (!in_ready);
    if (reach_step(cmd, ch, last, res))
      pending_results.push_back(typed ? typed_res : res);
    if (cmd != wbpr_pkg::CMD_NONE) items_sent++;
  endtask

  function automatic logic [7:0] pick_byte();
    // mostly a small alphabet so words actually line up; now and then anything
    if ($urandom_range(9) == 0) return 8'($urandom);
    return alphabet[$urandom_range(2)];
  endfunction

  // Directed table. Typed results only where they are obvious: empty
  // dictionary, a one-byte word hit, or a byte that is no word at all.
  stim_row_t directed_rows [24] = '{
    '{wbpr_pkg::CMD_TEXT,  8'h00, 1'b0, 1,  1'b1, '{1'b0, 1'b0, 1'b0}},  // fresh from reset
    '{wbpr_pkg::CMD_TEXT,  8'hff, 1'b1, 1,  1'b1, '{1'b0, 1'b1, 1'b0}},
    '{wbpr_pkg::CMD_NONE,  8'haa, 1'b1, 1,  1'b0, '0},                  // ignored code
    '{wbpr_pkg::CMD_DICT,  8'h61, 1'b1, 1,  1'b0, '0},                  // "a"
    '{wbpr_pkg::CMD_DICT,  8'hff, 1'b0, 1,  1'b0, '0},
    '{wbpr_pkg::CMD_DICT,  8'h00, 1'b1, 1,  1'b0, '0},                  // ff 00
    '{wbpr_pkg::CMD_TEXT,  8'h61, 1'b0, 1,  1'b0, '0},
    '{wbpr_pkg::CMD_TEXT,  8'hff, 1'b0, 1,  1'b0, '0},
    '{wbpr_pkg::CMD_TEXT,  8'h00, 1'b1, 1,  1'b0, '0},
    '{wbpr_pkg::CMD_DICT,  8'h42, 1'b0, 16, 1'b0, '0},                  // 17-byte word,
    '{wbpr_pkg::CMD_DICT,  8'h43, 1'b1, 1,  1'b0, '0},                  // dropped
    '{wbpr_pkg::CMD_TEXT,  8'h61, 1'b1, 1,  1'b1, '{1'b1, 1'b1, 1'b1}},
    '{wbpr_pkg::CMD_DICT,  8'h77, 1'b0, 1,  1'b0, '0},                  // partial word,
    '{wbpr_pkg::CMD_CLEAR, 8'h00, 1'b0, 1,  1'b0, '0},                  // thrown away
    '{wbpr_pkg::CMD_DICT,  8'h78, 1'b1, 1,  1'b0, '0},
    '{wbpr_pkg::CMD_TEXT,  8'h78, 1'b1, 1,  1'b0, '0},
    '{wbpr_pkg::CMD_CLEAR, 8'hff, 1'b1, 1,  1'b0, '0},
    '{wbpr_pkg::CMD_TEXT,  8'h61, 1'b1, 1,  1'b1, '{1'b0, 1'b1, 1'b0}},  // empty dictionary
    '{wbpr_pkg::CMD_DICT,  8'h31, 1'b1, 32, 1'b0, '0},                  // fill every row
    '{wbpr_pkg::CMD_DICT,  8'h32, 1'b1, 1,  1'b0, '0},                  // table full
    '{wbpr_pkg::CMD_TEXT,  8'h31, 1'b0, 1,  1'b0, '0},
    '{wbpr_pkg::CMD_TEXT,  8'h32, 1'b1, 1,  1'b1, '{1'b0, 1'b1, 1'b1}},
    '{wbpr_pkg::CMD_TEXT,  8'h31, 1'b0, 1,  1'b0, '0},                  // text open over
    '{wbpr_pkg::CMD_CLEAR, 8'h00, 1'b0, 1,  1'b0, '0}                   // a clear
  };

  // Receiver: random back-pressure, plus a long hold-off on each request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Checker: every result transfer against the oldest expectation.
  always @(posedge clk) begin
    reach_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_prefix_breakable !== want.breakable) begin
          $error("prefix_breakable: expected %0d, got %0d",
                 want.breakable, out_prefix_breakable);
          fail_count++;
        end
        if (out_text_end !== want.text_end) begin
          $error("text_end: expected %0d, got %0d", want.text_end, out_text_end);
          fail_count++;
        end
        if (out_dict_overflow !== want.overflow) begin
          $error("dict_overflow: expected %0d, got %0d",
                 want.overflow, out_dict_overflow);
          fail_count++;
        end
      end
    end
  end

  // Stimulus.
  initial begin
    int first_random;
    int span;
    int phase;
    int n_words;
    int n_texts;
    int n_pieces;
    int len;
    int w;
    int pick;
    logic final_piece;

    reach_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 23;
    recv_idle_pct = 50;
    foreach (directed_rows[r])
      repeat (directed_rows[r].reps)
        send_item(directed_rows[r].cmd, directed_rows[r].ch, directed_rows[r].last,
                  directed_rows[r].typed, directed_rows[r].res);
    send_item(wbpr_pkg::CMD_TEXT, 8'h31, 1'b1);   // closes the text left open above

    // Random phases: load a small dictionary, then texts mostly built from
    // its words, with stray commands mixed in. Idling changes by thirds.
    first_random = items_sent;
    span = (ITEM_TARGET - first_random) / 3;
    if (span < 1) span = 1;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case ((items_sent - first_random) / span)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 50;
        end
        1: begin
          send_idle_pct = 50;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      // sender pause: let everything in flight drain first
      if (phase == 1 || $urandom_range(3) == 0) begin
        if (pending_results.size() != 0) begin
          in_valid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
      end

      if ($urandom_range(9) < 8)
        send_item(wbpr_pkg::CMD_CLEAR, 8'($urandom), 1'($urandom));
      foreach (alphabet[i]) alphabet[i] = 8'($urandom);

      // occasionally push the table past full without a clear in between
      n_words = ($urandom_range(9) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 6);
      repeat (n_words) begin
        pick = $urandom_range(99);
        if (pick < 6) len = WORD_LEN;
        else if (pick < 11) len = $urandom_range(WORD_LEN + 1, WORD_LEN + 3);
        else len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++)
          send_item(wbpr_pkg::CMD_DICT, pick_byte(), k == len - 1);
      end

      // long receiver hold-off while texts keep coming, so the block backs up
      if (phase == 2 || phase == 9) hold_request = 1'b1;

      n_texts = $urandom_range(3, 6);
      repeat (n_texts) begin
        n_pieces = $urandom_range(1, 5);
        for (int p = 0; p < n_pieces; p++) begin
          final_piece = (p == n_pieces - 1);
          // stray transfers in the middle of a text
          pick = $urandom_range(99);
          if (pick < 3) send_item(wbpr_pkg::CMD_NONE, 8'($urandom), 1'($urandom));
          else if (pick < 5) send_item(wbpr_pkg::CMD_CLEAR, 8'($urandom), 1'($urandom));
          else if (pick < 7) send_item(wbpr_pkg::CMD_DICT, pick_byte(), 1'b1);

          if (word_count > 0 && $urandom_range(9) < 8) begin
            w = $urandom_range(word_count - 1);
            len = dict_len[w];
            for (int j = 0; j < len; j++)
              send_item(wbpr_pkg::CMD_TEXT, dict_bytes[w][j],
                        final_piece && j == len - 1);
          end else begin
            send_item(wbpr_pkg::CMD_TEXT, pick_byte(), final_piece);
          end
        end
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(12 * 400_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== word_break_prefix_reach_core.f =====
hw/rtl/wbpr_pkg.sv
hw/rtl/wbpr_ram.sv
hw/rtl/wbpr_match.sv
hw/rtl/word_break_prefix_reach_core.sv
tb/word_break_prefix_reach_core_test.sv
